>>> rtl/brdv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brdv_pkg
// shared types and constants of the back-emf rotation direction voter
// ----------------------------------------------------------------------------
package brdv_pkg;

  localparam int ADC_WIDTH_DEF  = 12;
  localparam int TIME_WIDTH_DEF = 48;

  localparam int NUM_STEPS    = 6;
  localparam int STEP_CODE_W  = 6;
  localparam int STEP_IDX_W   = 3;

  localparam int THRESH_W     = 9;
  localparam int LIMIT_W      = 8;
  localparam int TIMEOUT_W    = 20;
  localparam int TABLE_W      = NUM_STEPS * STEP_CODE_W;
  localparam int CFG_DATA_W   = TABLE_W;
  localparam int CFG_INDEX_W  = 2;
  localparam int VOTE_W       = 9;

  localparam int OUT_FIELDS_W = 2 + 1 + STEP_IDX_W + VOTE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [THRESH_W-1:0]  THRESH_RST  = THRESH_W'(20);
  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = LIMIT_W'(20);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(500000);

  localparam logic [1:0] PHASE_NONE = 2'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_VOTE_LIMIT = 2'd1,
    REG_TIMEOUT    = 2'd2,
    REG_STEP_TABLE = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  localparam logic [STEP_IDX_W-1:0] LAST_STEP_IDX = STEP_IDX_W'(NUM_STEPS - 1);

endpackage

>>> rtl/bemf_rotation_direction_voter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bemf_rotation_direction_voter
// votes on the rotation direction of an unpowered motor from back-emf samples
// ----------------------------------------------------------------------------
// Input channel s_*: one item is one three-phase ADC sample with its
// timestamp. Output channel m_*: one item per input item, carrying the
// direction decision, the matched step and the signed vote count.
// The configuration port writes threshold, vote limit, timeout and the
// packed step table; write it only while no item is in flight.
// The sample sits in the input register, then the six step compares, the
// timeout test and the saturating vote update run in one pass into the
// output register.
// Throughput is one item per cycle while the receiver accepts each result, set
// by that single pass and the vote state register it updates.
// Reset clears the vote state, the stage valids and loads the register
// defaults. When the receiver stalls, the result holds in the output
// register, one more sample can sit in the input register, and s_tready
// drops only when both are full.
// ----------------------------------------------------------------------------
module bemf_rotation_direction_voter #(
  parameter int  ADC_WIDTH  = brdv_pkg::ADC_WIDTH_DEF,
  parameter int  TIME_WIDTH = brdv_pkg::TIME_WIDTH_DEF,
  localparam int IN_TDATA_W = ((3 * ADC_WIDTH + TIME_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [brdv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [brdv_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // phase_a, phase_b, phase_c, sample_time
  input  logic [IN_TDATA_W-1:0]            s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // direction[1:0], step_found, found_step[2:0], vote_count[8:0]
  output logic [brdv_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int SUM_W  = ((ADC_WIDTH > brdv_pkg::THRESH_W) ? ADC_WIDTH : brdv_pkg::THRESH_W)
                          + 1;
  localparam int WIDE_W = brdv_pkg::VOTE_W + 1;

  // configuration
  logic [brdv_pkg::THRESH_W-1:0]  emf_thresh;
  logic [brdv_pkg::LIMIT_W-1:0]   vote_limit;
  logic [brdv_pkg::TIMEOUT_W-1:0] step_timeout;
  logic [brdv_pkg::TABLE_W-1:0]   step_table;

  always_ff @(posedge clk) begin
    if (rst) begin
      emf_thresh     <= brdv_pkg::THRESH_RST;
      vote_limit     <= brdv_pkg::LIMIT_RST;
      step_timeout   <= brdv_pkg::TIMEOUT_RST;
      step_table     <= '0;
    end else if (cfg_we) begin
      unique case (brdv_pkg::reg_index_t'(cfg_index))
        brdv_pkg::REG_THRESHOLD:  emf_thresh     <= cfg_data[brdv_pkg::THRESH_W-1:0];
        brdv_pkg::REG_VOTE_LIMIT: vote_limit     <= cfg_data[brdv_pkg::LIMIT_W-1:0];
        brdv_pkg::REG_TIMEOUT:    step_timeout   <= cfg_data[brdv_pkg::TIMEOUT_W-1:0];
        brdv_pkg::REG_STEP_TABLE: step_table     <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  logic in_valid;
  logic advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  logic [ADC_WIDTH-1:0]  in_pa;
  logic [ADC_WIDTH-1:0]  in_pb;
  logic [ADC_WIDTH-1:0]  in_pc;
  logic [TIME_WIDTH-1:0] in_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pa   <= s_tdata[ADC_WIDTH-1:0];
      in_pb   <= s_tdata[2*ADC_WIDTH-1:ADC_WIDTH];
      in_pc   <= s_tdata[3*ADC_WIDTH-1:2*ADC_WIDTH];
      in_time <= s_tdata[3*ADC_WIDTH+TIME_WIDTH-1:3*ADC_WIDTH];
    end
  end

  // vote state
  logic signed [brdv_pkg::VOTE_W-1:0] votes;
  logic [brdv_pkg::STEP_IDX_W-1:0]    last_step;
  logic [TIME_WIDTH-1:0]              last_count_time;

  function automatic logic [SUM_W-1:0] pick(input logic [1:0] code,
                                            input logic [SUM_W-1:0] a,
                                            input logic [SUM_W-1:0] b,
                                            input logic [SUM_W-1:0] c);
    logic [SUM_W-1:0] r;
    unique case (code)
      2'd0:    r = a;
      2'd1:    r = b;
      2'd2:    r = c;
      default: r = '0;
    endcase
    return r;
  endfunction

  // step match
  logic [brdv_pkg::NUM_STEPS-1:0] match;
  logic                           found;
  logic [brdv_pkg::STEP_IDX_W-1:0] idx;

  always_comb begin
    logic [SUM_W-1:0] va;
    logic [SUM_W-1:0] vb;
    logic [SUM_W-1:0] vc;
    logic [SUM_W-1:0] th;
    logic [SUM_W-1:0] vp;
    logic [SUM_W-1:0] vn;
    logic [SUM_W-1:0] vf;
    logic [brdv_pkg::STEP_CODE_W-1:0] code;
    va = SUM_W'(in_pa);
    vb = SUM_W'(in_pb);
    vc = SUM_W'(in_pc);
    th = SUM_W'(emf_thresh);
    for (int i = 0; i < brdv_pkg::NUM_STEPS; i++) begin
      code = step_table[i*brdv_pkg::STEP_CODE_W +: brdv_pkg::STEP_CODE_W];
      vp = pick(code[1:0], va, vb, vc);
      vn = pick(code[3:2], va, vb, vc);
      vf = pick(code[5:4], va, vb, vc);
      match[i] = (code[1:0] != brdv_pkg::PHASE_NONE) && (code[3:2] != brdv_pkg::PHASE_NONE)
                 && (code[5:4] != brdv_pkg::PHASE_NONE)
                 && (vf >= vn + th) && (vp >= vf + th);
    end
  end

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = brdv_pkg::NUM_STEPS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        idx   = brdv_pkg::STEP_IDX_W'(i);
      end
    end
  end

  // timeout and vote update
  logic [TIME_WIDTH-1:0]             gap;
  logic                              gap_expired;
  logic [brdv_pkg::STEP_IDX_W-1:0]   fwd_step;
  logic [brdv_pkg::STEP_IDX_W-1:0]   rev_step;
  logic                              is_fwd;
  logic                              is_rev;
  logic signed [WIDE_W-1:0]          lim;
  logic signed [WIDE_W-1:0]          base;
  logic signed [WIDE_W-1:0]          vote_wide;
  logic signed [brdv_pkg::VOTE_W-1:0] votes_next;
  logic [brdv_pkg::STEP_IDX_W-1:0]   last_step_next;
  logic [TIME_WIDTH-1:0]             last_count_time_next;
  brdv_pkg::dir_t                    dir;

  assign gap         = in_time - last_count_time;
  assign gap_expired = gap > TIME_WIDTH'(step_timeout);
  assign fwd_step    = (last_step == brdv_pkg::LAST_STEP_IDX) ? '0 : last_step + 1'b1;
  assign rev_step    = (last_step == '0) ? brdv_pkg::LAST_STEP_IDX : last_step - 1'b1;
  assign is_fwd      = found && (idx == fwd_step);
  assign is_rev      = found && (idx == rev_step);
  assign lim         = $signed({{(WIDE_W - brdv_pkg::LIMIT_W){1'b0}}, vote_limit});
  assign base        = gap_expired ? '0 : WIDE_W'(votes);

  always_comb begin
    vote_wide = base;
    if (is_fwd) begin
      vote_wide = base + WIDE_W'(1);
      if (vote_wide > lim) vote_wide = lim;
    end else if (is_rev) begin
      vote_wide = base - WIDE_W'(1);
      if (vote_wide < -lim) vote_wide = -lim;
    end
    votes_next           = vote_wide[brdv_pkg::VOTE_W-1:0];
    last_step_next       = found ? idx : last_step;
    last_count_time_next = (is_fwd || is_rev) ? in_time : last_count_time;
    priority if (vote_wide >= lim) begin
      dir = brdv_pkg::DIR_FWD;
    end else if (vote_wide <= -lim) begin
      dir = brdv_pkg::DIR_REV;
    end else begin
      dir = brdv_pkg::DIR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      votes           <= '0;
      last_step       <= '0;
      last_count_time <= '0;
    end else if (advance) begin
      votes           <= votes_next;
      last_step       <= last_step_next;
      last_count_time <= last_count_time_next;
    end
  end

  // output register
  logic [1:0]                          out_dir;
  logic                                out_found;
  logic [brdv_pkg::STEP_IDX_W-1:0]     out_step;
  logic signed [brdv_pkg::VOTE_W-1:0]  out_votes;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dir   <= dir;
      out_found <= found;
      out_step  <= idx;
      out_votes <= votes_next;
    end
  end

  assign m_tdata = brdv_pkg::OUT_TDATA_W'({out_votes, out_step, out_found, out_dir});

  // checks
  a_step_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_found |-> out_step == '0)
    else $error("found_step not zero without a match");

  a_last_step_range: assert property (@(posedge clk) disable iff (rst)
    last_step <= brdv_pkg::LAST_STEP_IDX)
    else $error("last_step out of range");

  a_fwd_means_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_dir == brdv_pkg::DIR_FWD |-> WIDE_W'(out_votes) >= lim)
    else $error("forward decision below vote limit");

  a_advance_loads_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result lost after advance");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("not ready after reset");

endmodule
